// File: hdl/bounded_binary_insertion_table_top_assert.svh
// assertion macros for the port-level checker of the sorted insertion table
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef BOUNDED_BINARY_INSERTION_TABLE_TOP_ASSERT_SVH
`define BOUNDED_BINARY_INSERTION_TABLE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BBIT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BBIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bbit_pkg.sv
// package for the sorted insertion table: field widths, codes, result struct
// no dependencies; imported by every module of the block
`default_nettype none

package bbit_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 6;
  localparam int STAT_W = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [IDX_W-1:0]         position;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/bbit_mem.sv
// entry store of the sorted table: one write port, one registered read port
// depends on bbit_pkg for the word width
`default_nettype none

module bbit_mem import bbit_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic signed [WORD_W-1:0]      rd_data,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic signed [WORD_W-1:0] wr_data
);

  logic signed [WORD_W-1:0] mem_r [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/bbit_seq.sv
// sequencer of the sorted table: binary search, shift-up, insert and drain
// depends on bbit_pkg; drives the ports of bbit_mem and hands results upward
`default_nettype none

module bbit_seq import bbit_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic                     in_kind,
  input  wire logic signed [WORD_W-1:0] in_value,
  input  wire logic [IDX_W-1:0]         in_search_hi,
  output logic                          in_ready,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  wire logic signed [WORD_W-1:0] rd_data,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic signed [WORD_W-1:0]      wr_data,
  input  wire logic                     res_free,
  output logic                          res_load,
  output res_t                          res
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SR_RD   = 4'd1;
  localparam logic [3:0] S_SR_CMP  = 4'd2;
  localparam logic [3:0] S_SH_RD   = 4'd3;
  localparam logic [3:0] S_SH_WR   = 4'd4;
  localparam logic [3:0] S_INS_WR  = 4'd5;
  localparam logic [3:0] S_EMIT    = 4'd6;
  localparam logic [3:0] S_DR_RD   = 4'd7;
  localparam logic [3:0] S_DR_EMIT = 4'd8;

  logic [3:0]               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [WORD_W-1:0] value_r, value_nxt;
  logic [CW-1:0]            lo_r, lo_nxt;
  logic [CW-1:0]            hp_r, hp_nxt;
  logic [AW-1:0]            mid_r, mid_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;

  logic [CW:0]              mid_sum;
  logic [AW-1:0]            mid_calc;
  logic [IDX_W:0]           bnd_ext;
  logic [IDX_W:0]           cnt_ext;
  logic [CW-1:0]            hp_init;
  logic                     cmp_gt;
  logic                     cmp_lt;
  logic                     full;
  logic                     drain_last;

  // hp is the exclusive upper bound, so mid = floor((lo + hi) / 2)
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hp_r} - (CW+1)'(1);
  assign mid_calc = AW'(mid_sum >> 1);

  // clamp search_hi to count - 1, kept as exclusive bound
  assign bnd_ext = {1'b0, in_search_hi} + (IDX_W+1)'(1);
  assign cnt_ext = (IDX_W+1)'(count_r);
  assign hp_init = (bnd_ext > cnt_ext) ? count_r : CW'(bnd_ext);

  // the compare unit of the binary search
  assign cmp_gt = value_r > rd_data;
  assign cmp_lt = value_r < rd_data;

  assign full       = (count_r == CW'(DEPTH));
  assign drain_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign in_ready   = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    value_nxt  = value_r;
    lo_nxt     = lo_r;
    hp_nxt     = hp_r;
    mid_nxt    = mid_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    rd_en      = 1'b0;
    rd_addr    = mid_calc;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_data;
    res_load   = 1'b0;
    res        = '0;
    res.position = IDX_W'(pos_r);
    res.status   = status_r;
    res.last     = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt  = in_value;
          status_nxt = ST_OK;
          if (in_kind == KIND_DRAIN) begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              pos_nxt    = '0;
              state_nxt  = S_EMIT;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_DR_RD;
            end
          end else if (full) begin
            status_nxt = ST_FULL;
            pos_nxt    = '0;
            state_nxt  = S_EMIT;
          end else if (count_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_INS_WR;
          end else begin
            lo_nxt    = '0;
            hp_nxt    = hp_init;
            state_nxt = S_SR_RD;
          end
        end
      end
      S_SR_RD: begin
        if (lo_r >= hp_r) begin
          // no match: lo is the insert point
          pos_nxt   = AW'(lo_r);
          idx_nxt   = AW'(count_r);
          state_nxt = S_SH_RD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = mid_calc;
          mid_nxt   = mid_calc;
          state_nxt = S_SR_CMP;
        end
      end
      S_SR_CMP: begin
        if (cmp_gt) begin
          lo_nxt    = CW'(mid_r) + CW'(1);
          state_nxt = S_SR_RD;
        end else if (cmp_lt) begin
          hp_nxt    = CW'(mid_r);
          state_nxt = S_SR_RD;
        end else begin
          pos_nxt   = mid_r;
          idx_nxt   = AW'(count_r);
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (idx_r == pos_r) begin
          state_nxt = S_INS_WR;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r - AW'(1);
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data;
        idx_nxt   = idx_r - AW'(1);
        state_nxt = S_SH_RD;
      end
      S_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = value_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DR_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_DR_EMIT;
      end
      S_DR_EMIT: begin
        res.word     = rd_data;
        res.position = IDX_W'(idx_r);
        res.status   = ST_OK;
        res.last     = drain_last;
        if (res_free) begin
          res_load = 1'b1;
          if (drain_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_DR_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    lo_r     <= lo_nxt;
    hp_r     <= hp_nxt;
    mid_r    <= mid_nxt;
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/bounded_binary_insertion_table_top.sv
// Sorted insertion table. Input channel in_* carries insert or drain items;
// output channel out_* carries results; both use valid / stall.
// An insert binary-searches entries 0..min(search_hi, count-1), moves the
// later entries up one place and stores the value; one result gives the
// position (status full and no change when the table is full).
// A drain emits every entry in order, last set on the final one, then
// empties the table; an empty table gives one result with status empty.
// Timing: one item at a time, in_stall is high until its results are
// queued. An insert into a non-empty table runs its search steps (at most
// log2(TABLE_DEPTH) + 1), each a read and a compare, stopping early when
// it hits an equal entry; it then moves the later entries up, each a read
// and a write, writes the value and loads its result. A drain reads each
// entry and loads its result in turn. The next transfer in is taken in the
// cycle after the last result is loaded. These steps are set by the single
// read port of the entry memory feeding the one compare unit.
// Results go through an output register: the next item is accepted while a
// result still waits, and a stalled receiver holds the sequencer only when
// it has another result to hand over.
// Reset empties the table (count to zero); entry contents are not cleared.
// Depends on bbit_pkg, bbit_mem and bbit_seq.
`default_nettype none

module bounded_binary_insertion_table_top import bbit_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_kind,
  input  wire logic signed [WORD_W-1:0] in_value,
  input  wire logic [IDX_W-1:0]         in_search_hi,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [WORD_W-1:0]      out_word,
  output logic [IDX_W-1:0]              out_position,
  output logic [STAT_W-1:0]             out_status,
  output logic                          out_last
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                     in_ready;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [WORD_W-1:0] rd_data;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [WORD_W-1:0] wr_data;
  logic                     res_free;
  logic                     res_load;
  res_t                     res;

  logic                     out_valid_r;
  res_t                     out_res_r;

  bbit_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bbit_seq #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .in_search_hi (in_search_hi),
    .in_ready     (in_ready),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res_free     (res_free),
    .res_load     (res_load),
    .res          (res)
  );

  assign in_stall = !in_ready;

  // output register is free when empty or being transferred this cycle
  assign res_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word     = out_res_r.word;
  assign out_position = out_res_r.position;
  assign out_status   = out_res_r.status;
  assign out_last     = out_res_r.last;

endmodule

`default_nettype wire

// File: hdl/bbit_chk.sv
// port-level checker for the sorted insertion table, bound to the top level
// depends on bbit_pkg and the assertion macro header
`default_nettype none
`include "bounded_binary_insertion_table_top_assert.svh"

module bbit_chk import bbit_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic signed [WORD_W-1:0] out_word,
  input wire logic [IDX_W-1:0]         out_position,
  input wire logic [STAT_W-1:0]        out_status,
  input wire logic                     out_last
);

  // a stalled result holds
  `BBIT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word) && $stable(out_position) && $stable(out_status) && $stable(out_last), "stalled result changed")

  // one item at a time: busy right after a transfer in
  `BBIT_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while busy")

  // full and empty-drain results are single, zero-payload results
  `BBIT_ASSERT_NOW(a_special_res, clk, rst_n, out_valid && (out_status == ST_FULL || out_status == ST_EMPTY), out_last && out_position == '0 && out_word == '0, "bad full or empty result")

  // a valid result carries one of the defined status codes
  `BBIT_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, out_status == ST_OK || out_status == ST_FULL || out_status == ST_EMPTY, "undefined status code")

endmodule

bind bounded_binary_insertion_table_top bbit_chk u_chk (.*);

`default_nettype wire

// File: bench/bbit_table_checker.sv
`timescale 1ns / 1ps
// checker for the sorted insertion table: mirrors the table contents, predicts
// the results of every accepted input transfer and compares the result stream
// depends on bbit_pkg for field widths, status codes and the result struct
module bbit_table_checker import bbit_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_kind,
  input  logic signed [WORD_W-1:0] in_value,
  input  logic [IDX_W-1:0]         in_search_hi,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [WORD_W-1:0] out_word,
  input  logic [IDX_W-1:0]         out_position,
  input  logic [STAT_W-1:0]        out_status,
  input  logic                     out_last,
  output int                       mismatch_count,
  output int                       pending_results,
  output int                       results_checked
);

  localparam int MAX_PRINTED = 40;

  logic signed [WORD_W-1:0] sorted_words [TABLE_DEPTH];
  int   fill = 0;
  int   fail_total = 0;
  int   checked_total = 0;
  int   waiting = 0;
  res_t expected_results [$];

  assign mismatch_count  = fail_total;
  assign pending_results = waiting;
  assign results_checked = checked_total;

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    // keep the log short when the block is badly off
    if (fail_total < MAX_PRINTED)
      $display("mismatch at %0t: %s, expected %h, got %h", $time, what, want, got);
    fail_total++;
  endtask

  task automatic push_result(input logic signed [WORD_W-1:0] word, input int pos,
                             input logic [STAT_W-1:0] status, input logic last);
    res_t r;
    r.word     = word;
    r.position = IDX_W'(pos);
    r.status   = status;
    r.last     = last;
    expected_results = {expected_results, r};
  endtask

  // binary search over entries 0..bound; equal value stops at the match
  function automatic int slot_for(input logic signed [WORD_W-1:0] v, input int bound);
    int lo = 0;
    int hi = bound;
    int mid = 0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (v > sorted_words[mid]) lo = mid + 1;
      else if (v < sorted_words[mid]) hi = mid - 1;
      else return mid;
    end
    return (v > sorted_words[mid]) ? mid + 1 : mid;
  endfunction

  task automatic predict_insert(input logic signed [WORD_W-1:0] v, input int search_hi);
    int pos;
    int bound;
    if (fill >= TABLE_DEPTH) begin
      push_result('0, 0, ST_FULL, 1'b1);
    end else begin
      if (fill == 0) begin
        pos = 0;
      end else begin
        bound = (search_hi > fill - 1) ? fill - 1 : search_hi;
        pos = slot_for(v, bound);
      end
      for (int i = fill; i > pos; i--) sorted_words[i] = sorted_words[i-1];
      sorted_words[pos] = v;
      fill++;
      push_result('0, pos, ST_OK, 1'b1);
    end
  endtask

  task automatic predict_drain();
    if (fill == 0) begin
      push_result('0, 0, ST_EMPTY, 1'b1);
    end else begin
      for (int i = 0; i < fill; i++) push_result(sorted_words[i], i, ST_OK, i == fill - 1);
      fill = 0;
    end
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      fill = 0;
      expected_results.delete();
      waiting <= 0;
    end else begin
      // results leave before the transfer taken at this edge can have any
      if (out_valid && !out_stall) begin
        checked_total++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", '0, out_word);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_word !== exp_r.word) report_mismatch("word", exp_r.word, out_word);
          if (out_position !== exp_r.position)
            report_mismatch("position", WORD_W'(exp_r.position), WORD_W'(out_position));
          if (out_status !== exp_r.status)
            report_mismatch("status", WORD_W'(exp_r.status), WORD_W'(out_status));
          if (out_last !== exp_r.last)
            report_mismatch("last", WORD_W'(exp_r.last), WORD_W'(out_last));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind == KIND_INSERT) predict_insert(in_value, int'(in_search_hi));
        else predict_drain();
      end
      waiting <= expected_results.size();
    end
  end

endmodule

// File: bench/bounded_binary_insertion_table_top_tb.sv
`timescale 1ns / 1ps
// top of the sorted insertion table bench: clock, reset, input and result
// stimulus with random idling, verdict; depends on bbit_pkg, the block and
// bbit_table_checker
module bounded_binary_insertion_table_top_tb;
  import bbit_pkg::*;

  localparam int TABLE_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 450;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 200;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_kind;
  logic signed [WORD_W-1:0] in_value;
  logic [IDX_W-1:0]         in_search_hi;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [WORD_W-1:0] out_word;
  logic [IDX_W-1:0]         out_position;
  logic [STAT_W-1:0]        out_status;
  logic                     out_last;

  int mismatches;
  int pending;
  int results_checked;
  int hold_requests = 0;
  int stim_fill = 0;
  int inserts_sent = 0;
  int full_inserts = 0;
  int drains_sent = 0;

  always #2 clk = ~clk;

  bounded_binary_insertion_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .in_search_hi (in_search_hi),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .out_position (out_position),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  bbit_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .in_search_hi    (in_search_hi),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word        (out_word),
    .out_position    (out_position),
    .out_status      (out_status),
    .out_last        (out_last),
    .mismatch_count  (mismatches),
    .pending_results (pending),
    .results_checked (results_checked)
  );

  // offer one item and return at the edge of its transfer; valid stays high
  task automatic send_item(input logic kind, input logic signed [WORD_W-1:0] value,
                           input logic [IDX_W-1:0] search_hi);
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_value     <= value;
    in_search_hi <= search_hi;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_INSERT) begin
      inserts_sent++;
      if (stim_fill >= TABLE_DEPTH) full_inserts++;
      else stim_fill++;
    end else begin
      drains_sent++;
      stim_fill = 0;
    end
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender pause: nothing offered until every expected result is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int run_len;
    int pick;
    int holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      if (hold_requests > holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          out_stall <= 1'b0;
          run_len = $urandom_range(1, 4);
        end else if (pick < 80) begin
          out_stall <= 1'b1;
          run_len = $urandom_range(1, 3);
        end else if (pick < 92) begin
          out_stall <= 1'b0;
          run_len = $urandom_range(20, 60);
        end else begin
          out_stall <= 1'b1;
          run_len = $urandom_range(10, 40);
        end
        repeat (run_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int seq = 0;
    int seq_len;
    int random_sent = 0;
    int pick;
    bit steady;
    logic signed [WORD_W-1:0] ins_value;
    logic [IDX_W-1:0]         ins_bound;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_kind      <= KIND_INSERT;
    in_value     <= '0;
    in_search_hi <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty drain, empty insert, zero and equal values, extremes, short
    // and oversized bounds, drain, drain of the emptied table, two inserts, drain
    send_item(KIND_DRAIN, 32'sh0, 6'd0);
    send_item(KIND_INSERT, 32'sh0, 6'd63);
    send_item(KIND_INSERT, 32'sh0, 6'd0);
    idle_sender(pick_gap());
    send_item(KIND_INSERT, 32'sh7fffffff, 6'd63);
    send_item(KIND_INSERT, 32'sh80000000, 6'd63);
    send_item(KIND_INSERT, -32'sd1, 6'd0);
    idle_sender(pick_gap());
    send_item(KIND_INSERT, 32'sd1, 6'd2);
    send_item(KIND_INSERT, 32'sh0, 6'd63);
    send_item(KIND_INSERT, 32'sd5, 6'd1);
    send_item(KIND_DRAIN, 32'shffffffff, 6'd63);
    send_item(KIND_DRAIN, 32'sh0, 6'd0);
    send_item(KIND_INSERT, -32'sd5, 6'd63);
    send_item(KIND_INSERT, 32'sh80000000, 6'd0);
    send_item(KIND_DRAIN, 32'sh0, 6'd0);
    wait_drained();

    // random: sorted-fill runs ending in a drain, with stray drains as noise
    while (random_sent < RANDOM_ITEMS) begin
      if (seq == 0) seq_len = TABLE_DEPTH + 2;
      else if (seq == 2) seq_len = 20;
      else if ($urandom_range(0, 7) == 0)
        seq_len = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 6);
      else seq_len = $urandom_range(1, 24);
      steady = ($urandom_range(0, 4) == 0);
      // receiver holds off while this run keeps offering, so the block backs up
      if (seq == 2) hold_requests <= hold_requests + 1;
      for (int k = 0; k < seq_len; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(KIND_DRAIN, $urandom(), IDX_W'($urandom_range(0, 63)));
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: ins_value = int'($urandom_range(0, 16)) - 8;
            4: case ($urandom_range(0, 3))
                 0: ins_value = 32'sh7fffffff;
                 1: ins_value = 32'sh80000000;
                 2: ins_value = 32'sh0;
                 default: ins_value = -32'sd1;
               endcase
            default: ins_value = $urandom();
          endcase
          pick = $urandom_range(0, 9);
          if (pick < 5) ins_bound = '1;
          else if (pick < 8) ins_bound = (stim_fill == 0) ? '0 : IDX_W'(stim_fill - 1);
          else ins_bound = IDX_W'($urandom_range(0, 63));
          send_item(KIND_INSERT, ins_value, ins_bound);
        end
        random_sent++;
        if (!steady) idle_sender(pick_gap());
      end
      send_item(KIND_DRAIN, $urandom(), IDX_W'($urandom_range(0, 63)));
      random_sent++;
      idle_sender(pick_gap());
      if (seq % 6 == 5) wait_drained();
      seq++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d inserts (%0d into a full table) and %0d drains in %0d runs",
             inserts_sent, full_inserts, drains_sent, seq);
    $display("%0d results compared, %0d failures", results_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
